// ===== design/tss_pkg.sv =====
// shared types and constants for the touch sample sequencer
`default_nettype none

package tss_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;
  localparam int unsigned SUM_HEADROOM = 3;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_X_AVG_LOG2     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_Y_AVG_LOG2     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_OPEN_DELAY = 2'd2;

  localparam logic [1:0] X_AVG_LOG2_RST     = 2'd2;
  localparam logic [1:0] Y_AVG_LOG2_RST     = 2'd1;
  localparam logic [3:0] KEY_OPEN_DELAY_RST = 4'd6;

  typedef enum logic [1:0] {
    CMD_PEN_EDGE = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_RESULT   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_IDLE    = 2'd1,
    MODE_DRIVE_X = 2'd2,
    MODE_DRIVE_Y = 2'd3
  } panel_mode_e;

  typedef struct packed {
    logic [1:0] x_avg_log2;
    logic [1:0] y_avg_log2;
    logic [3:0] key_open_delay;
  } cfg_t;

  typedef struct packed {
    panel_mode_e panel_mode;
    logic        adc_start;
    logic        adc_channel_y;
    logic        report_valid;
    logic        pen_up;
    logic        pen_irq_enable;
    logic        key_irq_enable;
    logic        timer_running;
    logic        sleep_allowed;
  } step_flags_t;

endpackage

`default_nettype wire

// ===== design/tss_if.sv =====
// valid/ready channels: event input, status result and register writes
`default_nettype none

interface tss_in_if
  import tss_pkg::*;
#(
  parameter int unsigned AdcBits = ADC_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [AdcBits-1:0] adc_sample;
  logic               adc_busy;
  logic               pen_level_low;

  modport source (output valid, cmd, adc_sample, adc_busy, pen_level_low, input ready);
  modport sink   (input valid, cmd, adc_sample, adc_busy, pen_level_low, output ready);
endinterface

interface tss_res_if
  import tss_pkg::*;
#(
  parameter int unsigned AdcBits = ADC_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [1:0]         panel_mode;
  logic               adc_start;
  logic               adc_channel_y;
  logic               report_valid;
  logic [AdcBits-1:0] x_pos;
  logic [AdcBits-1:0] y_pos;
  logic               pen_up;
  logic               pen_irq_enable;
  logic               key_irq_enable;
  logic               timer_running;
  logic               sleep_allowed;

  modport source (
    output valid, panel_mode, adc_start, adc_channel_y, report_valid, x_pos, y_pos,
           pen_up, pen_irq_enable, key_irq_enable, timer_running, sleep_allowed,
    input  ready
  );
  modport sink (
    input  valid, panel_mode, adc_start, adc_channel_y, report_valid, x_pos, y_pos,
           pen_up, pen_irq_enable, key_irq_enable, timer_running, sleep_allowed,
    output ready
  );
endinterface

interface tss_cfg_if
  import tss_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== design/tss_cfg_regs.sv =====
// configuration registers: averaging depths and key reopen delay
`default_nettype none

module tss_cfg_regs
  import tss_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tss_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_avg_log2     <= X_AVG_LOG2_RST;
      cfg_q.y_avg_log2     <= Y_AVG_LOG2_RST;
      cfg_q.key_open_delay <= KEY_OPEN_DELAY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        REG_X_AVG_LOG2:     cfg_q.x_avg_log2     <= cfg_i.data[1:0];
        REG_Y_AVG_LOG2:     cfg_q.y_avg_log2     <= cfg_i.data[1:0];
        REG_KEY_OPEN_DELAY: cfg_q.key_open_delay <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tss_step.sv =====
// sequencer state and the combinational step logic for one event
`default_nettype none

module tss_step
  import tss_pkg::*;
#(
  parameter int unsigned AdcBits = ADC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic [1:0]         cmd_i,
  input  wire logic [AdcBits-1:0] sample_i,
  input  wire logic               busy_i,
  input  wire logic               pen_low_i,
  input  wire cfg_t               cfg_i,
  output step_flags_t             flags_o,
  output logic [AdcBits-1:0]      x_pos_o,
  output logic [AdcBits-1:0]      y_pos_o
);

  localparam int unsigned SumW = AdcBits + SUM_HEADROOM;

  phase_e             phase_q, phase_d;
  logic               pressed_q, pressed_d;
  logic [CNT_W-1:0]   kcnt_q, kcnt_d;
  logic               kopen_q, kopen_d;
  logic [SumW-1:0]    sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0]   cnt_x_q, cnt_x_d, cnt_y_q, cnt_y_d;
  logic [AdcBits-1:0] x_q, x_d, y_q, y_d;
  logic               pen_up_q, pen_up_d;
  logic               pen_irq_q, pen_irq_d, key_irq_q, key_irq_d;
  logic               tmr_q, tmr_d, slp_q, slp_d;

  panel_mode_e        mode;
  logic               start, chy, rep, run_tick;
  logic [CNT_W-1:0]   thr_x, thr_y;

  assign thr_x = CNT_W'(1) << cfg_i.x_avg_log2;
  assign thr_y = CNT_W'(1) << cfg_i.y_avg_log2;

  always_comb begin
    phase_d   = phase_q;
    pressed_d = pressed_q;
    kcnt_d    = kcnt_q;
    kopen_d   = kopen_q;
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    cnt_x_d   = cnt_x_q;
    cnt_y_d   = cnt_y_q;
    x_d       = x_q;
    y_d       = y_q;
    pen_up_d  = pen_up_q;
    pen_irq_d = pen_irq_q;
    key_irq_d = key_irq_q;
    tmr_d     = tmr_q;
    slp_d     = slp_q;
    mode      = MODE_NONE;
    start     = 1'b0;
    chy       = 1'b0;
    rep       = 1'b0;
    run_tick  = 1'b0;

    case (cmd_e'(cmd_i))
      CMD_PEN_EDGE: begin
        slp_d     = 1'b0;
        pen_irq_d = 1'b0;
        key_irq_d = 1'b0;
        pressed_d = 1'b1;
        kcnt_d    = '0;
        kopen_d   = 1'b0;
        // a fresh press also runs the tick actions and starts the timer
        if (!pressed_q) begin
          run_tick = 1'b1;
          tmr_d    = 1'b1;
        end
      end
      CMD_TICK: run_tick = 1'b1;
      CMD_RESULT: begin
        case (phase_q)
          PH_X: begin
            sum_x_d = sum_x_q + SumW'(sample_i);
            cnt_x_d = cnt_x_q + CNT_W'(1);
            start   = 1'b1;
            if (cnt_x_d >= thr_x) begin
              x_d     = AdcBits'(sum_x_d >> cfg_i.x_avg_log2);
              sum_x_d = '0;
              cnt_x_d = '0;
              phase_d = PH_Y;
              mode    = MODE_DRIVE_Y;
              chy     = 1'b1;
            end
          end
          PH_Y: begin
            sum_y_d = sum_y_q + SumW'(sample_i);
            cnt_y_d = cnt_y_q + CNT_W'(1);
            if (cnt_y_d < thr_y) begin
              start = 1'b1;
              chy   = 1'b1;
            end else begin
              y_d     = AdcBits'(sum_y_d >> cfg_i.y_avg_log2);
              sum_y_d = '0;
              cnt_y_d = '0;
              mode    = MODE_IDLE;
              rep     = 1'b1;
              phase_d = PH_IDLE;
              pen_up_d = !pen_low_i;
              // pen lifted: re-arm the interrupts and leave the pressed state
              if (!pen_low_i) begin
                pressed_d = 1'b0;
                pen_irq_d = 1'b1;
                key_irq_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (run_tick) begin
      if (!pressed_d) begin
        tmr_d = 1'b0;
        slp_d = 1'b1;
      end else begin
        if (!kopen_d) begin
          if (kcnt_d < cfg_i.key_open_delay) begin
            kcnt_d = kcnt_d + CNT_W'(1);
          end else begin
            key_irq_d = 1'b1;
            kopen_d   = 1'b1;
          end
        end
        if (phase_d == PH_IDLE && !busy_i) begin
          phase_d = PH_X;
          mode    = MODE_DRIVE_X;
          start   = 1'b1;
          chy     = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      pressed_q <= 1'b0;
      kcnt_q    <= '0;
      kopen_q   <= 1'b1;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      cnt_x_q   <= '0;
      cnt_y_q   <= '0;
      x_q       <= '0;
      y_q       <= '0;
      pen_up_q  <= 1'b1;
      pen_irq_q <= 1'b1;
      key_irq_q <= 1'b1;
      tmr_q     <= 1'b0;
      slp_q     <= 1'b1;
    end else if (adv_i) begin
      phase_q   <= phase_d;
      pressed_q <= pressed_d;
      kcnt_q    <= kcnt_d;
      kopen_q   <= kopen_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      cnt_x_q   <= cnt_x_d;
      cnt_y_q   <= cnt_y_d;
      x_q       <= x_d;
      y_q       <= y_d;
      pen_up_q  <= pen_up_d;
      pen_irq_q <= pen_irq_d;
      key_irq_q <= key_irq_d;
      tmr_q     <= tmr_d;
      slp_q     <= slp_d;
    end
  end

  always_comb begin
    flags_o.panel_mode     = mode;
    flags_o.adc_start      = start;
    flags_o.adc_channel_y  = chy;
    flags_o.report_valid   = rep;
    flags_o.pen_up         = pen_up_d;
    flags_o.pen_irq_enable = pen_irq_d;
    flags_o.key_irq_enable = key_irq_d;
    flags_o.timer_running  = tmr_d;
    flags_o.sleep_allowed  = slp_d;
  end

  assign x_pos_o = x_d;
  assign y_pos_o = y_d;

endmodule

`default_nettype wire

// ===== design/touch_sample_sequencer_top.sv =====
// an accepted event is held in the input register, stepped into the result register and then given as its status beat
// throughput: one event per cycle while status beats are taken; the sequencer state updates in a single step per event
// a full result register still accepts a new event when the result beat is taken that cycle
// reset: asynchronous, active low; sequencer idle, pen up, pen and key irqs and sleep on,
// timer off, averaging depths 4 and 2, key reopen delay 6; no clearing pass
`default_nettype none

module touch_sample_sequencer_top
  import tss_pkg::*;
#(
  parameter int unsigned AdcBits = ADC_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tss_cfg_if.sink   cfg_i,
  tss_in_if.sink    in_i,
  tss_res_if.source res_o
);

  cfg_t               cfg;
  logic               adv;
  logic               in_vq;
  logic [1:0]         cmd_q;
  logic [AdcBits-1:0] sample_q;
  logic               busy_q, pen_low_q;
  logic               out_vq;
  step_flags_t        flags_d, flags_q;
  logic [AdcBits-1:0] x_pos_d, x_pos_q, y_pos_d, y_pos_q;

  tss_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // the step fires when the result register is free or being drained
  assign adv        = in_vq && (!out_vq || res_o.ready);
  assign in_i.ready = !in_vq || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q     <= in_i.cmd;
      sample_q  <= in_i.adc_sample;
      busy_q    <= in_i.adc_busy;
      pen_low_q <= in_i.pen_level_low;
    end
  end

  tss_step #(
    .AdcBits (AdcBits)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .cmd_i     (cmd_q),
    .sample_i  (sample_q),
    .busy_i    (busy_q),
    .pen_low_i (pen_low_q),
    .cfg_i     (cfg),
    .flags_o   (flags_d),
    .x_pos_o   (x_pos_d),
    .y_pos_o   (y_pos_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (adv) begin
      out_vq <= 1'b1;
    end else if (res_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flags_q <= flags_d;
      x_pos_q <= x_pos_d;
      y_pos_q <= y_pos_d;
    end
  end

  assign res_o.valid          = out_vq;
  assign res_o.panel_mode     = flags_q.panel_mode;
  assign res_o.adc_start      = flags_q.adc_start;
  assign res_o.adc_channel_y  = flags_q.adc_channel_y;
  assign res_o.report_valid   = flags_q.report_valid;
  assign res_o.x_pos          = x_pos_q;
  assign res_o.y_pos          = y_pos_q;
  assign res_o.pen_up         = flags_q.pen_up;
  assign res_o.pen_irq_enable = flags_q.pen_irq_enable;
  assign res_o.key_irq_enable = flags_q.key_irq_enable;
  assign res_o.timer_running  = flags_q.timer_running;
  assign res_o.sleep_allowed  = flags_q.sleep_allowed;

  // a position report always returns the panel to idle bias
  a_report_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.report_valid |-> res_o.panel_mode == MODE_IDLE)
    else $error("report without idle bias");

  // the Y channel is only named for a conversion that is started
  a_chy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.adc_channel_y |-> res_o.adc_start)
    else $error("channel y without start");

  // pen and key irqs are re-armed together, key may open alone
  a_pen_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.pen_irq_enable |-> res_o.key_irq_enable)
    else $error("pen irq enabled with key irq off");

  // a held event is never dropped while the result register is blocked
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vq && !adv |=> in_vq)
    else $error("pending event lost");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the touch sample sequencer: random events, predicted status beats
`timescale 1ns / 100ps

module testbench;
  import tss_pkg::*;

  localparam logic [1:0]            CMD_UNUSED   = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int unsigned           PhaseItems   = 120;
  localparam int unsigned           NumPhases    = 8;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [ADC_BITS_DEF-1:0] sample;
    logic                    busy;
    logic                    pen_low;
  } touch_evt_t;

  typedef struct packed {
    panel_mode_e             mode;
    logic                    start;
    logic                    chan_y;
    logic                    report;
    logic [ADC_BITS_DEF-1:0] x_pos;
    logic [ADC_BITS_DEF-1:0] y_pos;
    logic                    pen_up;
    logic                    pen_irq;
    logic                    key_irq;
    logic                    timer_on;
    logic                    sleep_ok;
  } status_t;

  logic clk_i;
  logic rst_ni;

  tss_cfg_if                             reg_if ();
  tss_in_if  #(.AdcBits(ADC_BITS_DEF))   evt_if ();
  tss_res_if #(.AdcBits(ADC_BITS_DEF))   stat_if ();

  touch_sample_sequencer_top #(
    .AdcBits(ADC_BITS_DEF)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (reg_if),
    .in_i  (evt_if),
    .res_o (stat_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  touch_evt_t pending_events[$];
  status_t    expected_status[$];
  int         mismatch_count = 0;
  int         snd_idle_pct   = 0;
  int         rcv_stall_pct  = 0;

  // sequencer shadow state
  cfg_t        seq_cfg      = '{X_AVG_LOG2_RST, Y_AVG_LOG2_RST, KEY_OPEN_DELAY_RST};
  phase_e      seq_phase    = PH_IDLE;
  logic        pen_pressed  = 1'b0;
  logic [3:0]  key_cnt      = '0;
  logic        key_open     = 1'b1;
  logic [14:0] sum_x        = '0;
  logic [14:0] sum_y        = '0;
  logic [3:0]  cnt_x        = '0;
  logic [3:0]  cnt_y        = '0;
  logic [11:0] x_lat        = '0;
  logic [11:0] y_lat        = '0;
  logic        pen_up_st    = 1'b1;
  logic        pen_irq_on   = 1'b1;
  logic        key_irq_on   = 1'b1;
  logic        timer_on     = 1'b0;
  logic        sleep_on     = 1'b1;
  status_t     step_out;

  function automatic void run_tick(input logic busy);
    if (!pen_pressed) begin
      timer_on = 1'b0;
      sleep_on = 1'b1;
    end else begin
      if (!key_open) begin
        if (key_cnt < seq_cfg.key_open_delay) begin
          key_cnt = key_cnt + 4'd1;
        end else begin
          key_irq_on = 1'b1;
          key_open   = 1'b1;
        end
      end
      if (seq_phase == PH_IDLE && !busy) begin
        seq_phase       = PH_X;
        step_out.mode   = MODE_DRIVE_X;
        step_out.start  = 1'b1;
        step_out.chan_y = 1'b0;
      end
    end
  endfunction

  function automatic void take_sample(input logic [11:0] sample, input logic pen_low);
    if (seq_phase == PH_X) begin
      sum_x          = sum_x + 15'(sample);
      cnt_x          = cnt_x + 4'd1;
      step_out.start = 1'b1;
      if (cnt_x >= (5'd1 << seq_cfg.x_avg_log2)) begin
        x_lat           = 12'(sum_x >> seq_cfg.x_avg_log2);
        sum_x           = '0;
        cnt_x           = '0;
        seq_phase       = PH_Y;
        step_out.mode   = MODE_DRIVE_Y;
        step_out.chan_y = 1'b1;
      end
    end else if (seq_phase == PH_Y) begin
      sum_y = sum_y + 15'(sample);
      cnt_y = cnt_y + 4'd1;
      if (cnt_y < (5'd1 << seq_cfg.y_avg_log2)) begin
        step_out.start  = 1'b1;
        step_out.chan_y = 1'b1;
      end else begin
        y_lat           = 12'(sum_y >> seq_cfg.y_avg_log2);
        sum_y           = '0;
        cnt_y           = '0;
        step_out.mode   = MODE_IDLE;
        step_out.report = 1'b1;
        if (!pen_low) begin
          // pen lifted: leave the pressed state and re-arm both irqs
          pen_up_st   = 1'b1;
          pen_pressed = 1'b0;
          pen_irq_on  = 1'b1;
          key_irq_on  = 1'b1;
        end else begin
          pen_up_st = 1'b0;
        end
        seq_phase = PH_IDLE;
      end
    end
  endfunction

  function automatic status_t predict_status(input touch_evt_t evt);
    logic was_pressed;
    step_out        = '0;
    step_out.mode   = MODE_NONE;
    was_pressed     = pen_pressed;
    case (evt.cmd)
      CMD_PEN_EDGE: begin
        pen_irq_on  = 1'b0;
        key_irq_on  = 1'b0;
        sleep_on    = 1'b0;
        pen_pressed = 1'b1;
        key_cnt     = '0;
        key_open    = 1'b0;
        if (!was_pressed) begin
          run_tick(evt.busy);
          timer_on = 1'b1;
        end
      end
      CMD_TICK:   run_tick(evt.busy);
      CMD_RESULT: take_sample(evt.sample, evt.pen_low);
      default: ;
    endcase
    step_out.x_pos    = x_lat;
    step_out.y_pos    = y_lat;
    step_out.pen_up   = pen_up_st;
    step_out.pen_irq  = pen_irq_on;
    step_out.key_irq  = key_irq_on;
    step_out.timer_on = timer_on;
    step_out.sleep_ok = sleep_on;
    return step_out;
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want_v,
                                      input logic [11:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // event driver: next beat once the current one is taken
  always @(posedge clk_i) begin : drive_events
    touch_evt_t evt;
    if (rst_ni && (!evt_if.valid || evt_if.ready)) begin
      if (pending_events.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        evt                  = pending_events.pop_front();
        evt_if.valid         <= 1'b1;
        evt_if.cmd           <= evt.cmd;
        evt_if.adc_sample    <= evt.sample;
        evt_if.adc_busy      <= evt.busy;
        evt_if.pen_level_low <= evt.pen_low;
      end else begin
        evt_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : drive_ready
    if (rst_ni) begin
      stat_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch_beats
    touch_evt_t evt;
    status_t    want;
    if (rst_ni) begin
      if (reg_if.valid && reg_if.ready) begin
        case (reg_if.addr)
          REG_X_AVG_LOG2:     seq_cfg.x_avg_log2     = reg_if.data[1:0];
          REG_Y_AVG_LOG2:     seq_cfg.y_avg_log2     = reg_if.data[1:0];
          REG_KEY_OPEN_DELAY: seq_cfg.key_open_delay = reg_if.data;
          default: ;
        endcase
      end
      if (evt_if.valid && evt_if.ready) begin
        evt = '{evt_if.cmd, evt_if.adc_sample, evt_if.adc_busy, evt_if.pen_level_low};
        expected_status.push_back(predict_status(evt));
      end
      if (stat_if.valid && stat_if.ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t ns: status beat with none expected, expected none actual mode %0d",
                   $time, stat_if.panel_mode);
          mismatch_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("panel_mode", 12'(want.mode), 12'(stat_if.panel_mode));
          check_field("adc_start", 12'(want.start), 12'(stat_if.adc_start));
          check_field("adc_channel_y", 12'(want.chan_y), 12'(stat_if.adc_channel_y));
          check_field("report_valid", 12'(want.report), 12'(stat_if.report_valid));
          check_field("x_pos", want.x_pos, stat_if.x_pos);
          check_field("y_pos", want.y_pos, stat_if.y_pos);
          check_field("pen_up", 12'(want.pen_up), 12'(stat_if.pen_up));
          check_field("pen_irq_enable", 12'(want.pen_irq), 12'(stat_if.pen_irq_enable));
          check_field("key_irq_enable", 12'(want.key_irq), 12'(stat_if.key_irq_enable));
          check_field("timer_running", 12'(want.timer_on), 12'(stat_if.timer_running));
          check_field("sleep_allowed", 12'(want.sleep_ok), 12'(stat_if.sleep_allowed));
        end
      end
    end
  end

  function automatic logic [11:0] rand_sample();
    if ($urandom_range(0, 9) == 0) begin
      return {12{1'($urandom_range(0, 1))}};
    end
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic push_event(input logic [1:0] cmd, input logic [11:0] sample,
                            input logic busy, input logic pen_low);
    pending_events.push_back('{cmd, sample, busy, pen_low});
  endtask

  // occasional junk beat: any command, any field values
  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 10) begin
      push_event(2'($urandom_range(0, 3)), rand_sample(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic maybe_tick();
    if ($urandom_range(0, 99) < 40) begin
      push_event(CMD_TICK, rand_sample(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // pen down, a few positions of X then Y averages, usually lifting on the last one
  task automatic add_touch(input bit partial);
    int npos;
    int nx;
    int ny;
    logic pen_low;
    npos = partial ? 1 : $urandom_range(1, 3);
    nx   = 1 << seq_cfg.x_avg_log2;
    ny   = 1 << seq_cfg.y_avg_log2;
    push_event(CMD_PEN_EDGE, rand_sample(), ($urandom_range(0, 3) == 0),
               1'($urandom_range(0, 1)));
    for (int p = 0; p < npos; p++) begin
      repeat ($urandom_range(0, 2)) begin
        push_event(CMD_TICK, rand_sample(), ($urandom_range(0, 4) == 0),
                   1'($urandom_range(0, 1)));
      end
      push_event(CMD_TICK, rand_sample(), 1'b0, 1'($urandom_range(0, 1)));
      if (partial) begin
        nx = $urandom_range(0, nx);
        ny = 0;
      end
      for (int i = 0; i < nx; i++) begin
        maybe_noise();
        maybe_tick();
        push_event(CMD_RESULT, rand_sample(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < ny; i++) begin
        maybe_noise();
        maybe_tick();
        if (i != ny - 1) pen_low = 1'($urandom_range(0, 1));
        else if (p != npos - 1) pen_low = 1'b1;
        else pen_low = ($urandom_range(0, 4) == 0);
        push_event(CMD_RESULT, rand_sample(), 1'($urandom_range(0, 1)), pen_low);
      end
    end
    if (!partial) begin
      repeat ($urandom_range(1, 3)) begin
        push_event(CMD_TICK, rand_sample(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    reg_if.valid <= 1'b1;
    reg_if.addr  <= addr;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [1:0] xl, input logic [1:0] yl,
                               input logic [3:0] dly);
    // upper data bits of the averaging registers are don't-care
    write_register(REG_X_AVG_LOG2, {2'($urandom_range(0, 3)), xl});
    write_register(REG_Y_AVG_LOG2, {2'($urandom_range(0, 3)), yl});
    write_register(REG_KEY_OPEN_DELAY, dly);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_events.size() != 0 || evt_if.valid || expected_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin : run_phases
    int   snd_tab[4];
    int   rcv_tab[4];
    logic [1:0] xl;
    logic [1:0] yl;
    logic [3:0] dly;
    snd_tab              = '{0, 55, 0, 14};
    rcv_tab              = '{0, 0, 55, 14};
    rst_ni               = 1'b0;
    evt_if.valid         = 1'b0;
    evt_if.cmd           = CMD_TICK;
    evt_if.adc_sample    = '0;
    evt_if.adc_busy      = 1'b0;
    evt_if.pen_level_low = 1'b0;
    stat_if.ready        = 1'b0;
    reg_if.valid         = 1'b0;
    reg_if.addr          = REG_X_AVG_LOG2;
    reg_if.data          = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset averaging depths 4 and 2
    push_event(CMD_UNUSED, 12'hfff, 1'b1, 1'b1);
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b1);   // result with nothing sampling
    push_event(CMD_TICK, 12'h000, 1'b0, 1'b0);     // tick with pen up
    push_event(CMD_PEN_EDGE, 12'h000, 1'b1, 1'b0); // converter busy, no X start
    push_event(CMD_TICK, 12'h000, 1'b1, 1'b0);
    push_event(CMD_TICK, 12'h000, 1'b0, 1'b0);
    push_event(CMD_PEN_EDGE, 12'h000, 1'b0, 1'b0); // edge while pressed
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b0);
    push_event(CMD_RESULT, 12'h000, 1'b1, 1'b1);
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b0);
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b0);
    push_event(CMD_RESULT, 12'h000, 1'b0, 1'b0);
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b1);   // pen still down
    push_event(CMD_TICK, 12'h000, 1'b0, 1'b0);
    repeat (4) push_event(CMD_RESULT, 12'hfff, 1'b1, 1'b0);
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b1);
    push_event(CMD_RESULT, 12'hfff, 1'b0, 1'b0);   // pen lifted
    push_event(CMD_TICK, 12'hfff, 1'b1, 1'b1);     // stops the timer
    wait_drained();

    write_register(REG_UNMAPPED, 4'($urandom_range(0, 15)));
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin xl = 2'd0; yl = 2'd0; dly = 4'd0;  end
        1: begin xl = 2'd3; yl = 2'd3; dly = 4'd15; end
        2: begin xl = 2'd1; yl = 2'd2; dly = 4'd3;  end
        3: begin xl = 2'd2; yl = 2'd1; dly = 4'd6;  end
        default: begin
          xl  = 2'($urandom_range(0, 3));
          yl  = 2'($urandom_range(0, 3));
          dly = 4'($urandom_range(0, 15));
        end
      endcase
      apply_setting(xl, yl, dly);
      snd_idle_pct  = snd_tab[ph % 4];
      rcv_stall_pct = rcv_tab[ph % 4];
      while (pending_events.size() < PhaseItems) add_touch(1'b0);
      // leave some phases part way through an average for the next register change
      if ($urandom_range(0, 1) == 1) add_touch(1'b1);
      wait_drained();
    end

    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
